>>> design/clr_pkg.sv
// ----------------------------------------------------------------------------
// Clipped line rasteriser package
// Shared constants and types: register widths, register indexes, reset
// values and the canvas descriptor that the top level hands to the stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package clr_pkg;

   // Configuration register widths and the CSR port geometry.
   localparam int CFG_BITS      = 7;
   localparam int PEN_BITS      = 8;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;

   // Register indexes, taken from the word address.
   localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
   localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
   localparam logic [1:0] REG_PEN_VALUE     = 2'd2;

   // Reset values of the registers.
   localparam logic [CFG_BITS-1:0] RESET_CANVAS_SIDE = 7'd64;
   localparam logic [PEN_BITS-1:0] RESET_PEN_VALUE   = 8'd42;

   // Canvas sides after saturation to the largest supported side.
   typedef struct packed {
      logic [CFG_BITS-1:0] width;
      logic [CFG_BITS-1:0] height;
   } canvas_type;

endpackage

`default_nettype wire

>>> design/clr_fifo.sv
// ----------------------------------------------------------------------------
// Clipped line rasteriser queue
// A small first-in first-out queue of registers with full and empty flags,
// used between the front and the stepper and again in front of the result
// channel.
// ----------------------------------------------------------------------------
`default_nettype none

module clr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and fill count update, with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Storage needs no reset; the pointers and the count do.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> design/clr_front.sv
// ----------------------------------------------------------------------------
// Clipped line rasteriser front end
// Classifies a segment: forms the axis differences and their magnitudes,
// picks the major axis and packs a step descriptor for the stepper.
// ----------------------------------------------------------------------------
`default_nettype none

module clr_front #(
   parameter int COORD_BITS = 12
) (
   input  logic [COORD_BITS-1:0]   x_start,
   input  logic [COORD_BITS-1:0]   y_start,
   input  logic [COORD_BITS-1:0]   x_end,
   input  logic [COORD_BITS-1:0]   y_end,
   output logic [4*COORD_BITS+2:0] desc
);

   localparam int C = COORD_BITS;

   logic [C:0]   dx;
   logic [C:0]   dy;
   logic [C:0]   adx_w;
   logic [C:0]   ady_w;
   logic [C-1:0] adx;
   logic [C-1:0] ady;
   logic         x_major;
   logic [C-1:0] steps;
   logic [C-1:0] minor_mag;
   logic         major_neg;
   logic         minor_neg;

   // Signed differences, one bit wider than the coordinates.
   assign dx = {x_end[C-1], x_end} - {x_start[C-1], x_start};
   assign dy = {y_end[C-1], y_end} - {y_start[C-1], y_start};

   // Magnitudes always fit in the coordinate width.
   assign adx_w = dx[C] ? (~dx + 1'b1) : dx;
   assign ady_w = dy[C] ? (~dy + 1'b1) : dy;
   assign adx   = adx_w[C-1:0];
   assign ady   = ady_w[C-1:0];

   // The x axis leads on a tie.
   assign x_major   = (adx >= ady);
   assign steps     = x_major ? adx : ady;
   assign minor_mag = x_major ? ady : adx;
   assign major_neg = x_major ? dx[C] : dy[C];
   assign minor_neg = x_major ? dy[C] : dx[C];

   assign desc = {x_start, y_start, steps, minor_mag, x_major, major_neg, minor_neg};

endmodule

`default_nettype wire

>>> design/clr_stepper.sv
// ----------------------------------------------------------------------------
// Clipped line rasteriser stepper
// Walks one segment a point per cycle along its major axis, halting while
// out_full is high, and carries the minor axis with a remainder accumulator.
// It emits the points on the canvas, holding one back to mark the final one.
// ----------------------------------------------------------------------------
`default_nettype none

module clr_stepper
   import clr_pkg::*;
#(
   parameter int MAX_CANVAS = 64,
   parameter int COORD_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [4*COORD_BITS+2:0]             desc,
   input  logic                                desc_valid,
   output logic                                desc_pop,
   input  canvas_type                          canvas,
   output logic                                out_push,
   output logic [2*$clog2(MAX_CANVAS):0]       out_data,
   input  logic                                out_full
);

   localparam int C   = COORD_BITS;
   localparam int PIX = $clog2(MAX_CANVAS);
   localparam int CMP = ((C > CFG_BITS) ? C : CFG_BITS) + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_FLUSH
   } state_type;

   // Descriptor fields.
   logic [C-1:0] d_x0;
   logic [C-1:0] d_y0;
   logic [C-1:0] d_steps;
   logic [C-1:0] d_minor;
   logic         d_x_major;
   logic         d_major_neg;
   logic         d_minor_neg;

   state_type    state_ff, state_in;
   logic [C-1:0] maj_ff, maj_in;
   logic [C-1:0] min_ff, min_in;
   logic [C-1:0] remain_ff, remain_in;
   logic [C-1:0] steps_ff, steps_in;
   logic [C-1:0] dm_ff, dm_in;
   logic [C-1:0] acc_ff, acc_in;
   logic         x_major_ff, x_major_in;
   logic         major_neg_ff, major_neg_in;
   logic         minor_neg_ff, minor_neg_in;
   logic         pend_valid_ff, pend_valid_in;
   logic [PIX-1:0] pend_x_ff, pend_x_in;
   logic [PIX-1:0] pend_y_ff, pend_y_in;

   logic [C-1:0]          cur_x;
   logic [C-1:0]          cur_y;
   logic signed [CMP-1:0] x_ext;
   logic signed [CMP-1:0] y_ext;
   logic signed [CMP-1:0] maj_ext;
   logic signed [CMP-1:0] w_ext;
   logic signed [CMP-1:0] h_ext;
   logic signed [CMP-1:0] side_ext;
   logic                  on_canvas;
   logic                  beyond;
   logic [C:0]            acc_sum;
   logic                  carry;
   logic [C:0]            acc_next;

   assign {d_x0, d_y0, d_steps, d_minor, d_x_major, d_major_neg, d_minor_neg} = desc;

   // Current point and its canvas test.
   assign cur_x    = x_major_ff ? maj_ff : min_ff;
   assign cur_y    = x_major_ff ? min_ff : maj_ff;
   assign x_ext    = CMP'($signed(cur_x));
   assign y_ext    = CMP'($signed(cur_y));
   assign maj_ext  = CMP'($signed(maj_ff));
   assign w_ext    = CMP'(canvas.width);
   assign h_ext    = CMP'(canvas.height);
   assign side_ext = x_major_ff ? w_ext : h_ext;
   assign on_canvas = !x_ext[CMP-1] && (x_ext < w_ext) && !y_ext[CMP-1] && (y_ext < h_ext);

   // Once the major axis has left the canvas in its direction of travel,
   // no later point can come back onto it.
   assign beyond = major_neg_ff ? maj_ff[C-1] : (maj_ext >= side_ext);

   // Remainder accumulator: the minor axis moves by at most one per step.
   assign acc_sum  = {1'b0, acc_ff} + {1'b0, dm_ff};
   assign carry    = (acc_sum >= {1'b0, steps_ff});
   assign acc_next = carry ? (acc_sum - {1'b0, steps_ff}) : acc_sum;

   // Next state and datapath values.
   always_comb begin
      state_in      = state_ff;
      maj_in        = maj_ff;
      min_in        = min_ff;
      remain_in     = remain_ff;
      steps_in      = steps_ff;
      dm_in         = dm_ff;
      acc_in        = acc_ff;
      x_major_in    = x_major_ff;
      major_neg_in  = major_neg_ff;
      minor_neg_in  = minor_neg_ff;
      pend_valid_in = pend_valid_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      desc_pop      = 1'b0;
      out_push      = 1'b0;
      out_data      = {pend_x_ff, pend_y_ff, 1'b0};
      case (state_ff)
         ST_IDLE: begin
            if (desc_valid) begin
               desc_pop      = 1'b1;
               maj_in        = d_x_major ? d_x0 : d_y0;
               min_in        = d_x_major ? d_y0 : d_x0;
               remain_in     = d_steps;
               steps_in      = d_steps;
               dm_in         = d_minor;
               acc_in        = '0;
               x_major_in    = d_x_major;
               major_neg_in  = d_major_neg;
               minor_neg_in  = d_minor_neg;
               pend_valid_in = 1'b0;
               state_in      = ST_STEP;
            end
         end
         ST_STEP: begin
            if (!out_full) begin
               // A new point on the canvas releases the one held back.
               if (on_canvas) begin
                  out_push      = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_x_in     = cur_x[PIX-1:0];
                  pend_y_in     = cur_y[PIX-1:0];
               end
               if ((remain_ff == '0) || beyond) begin
                  state_in = ST_FLUSH;
               end else begin
                  remain_in = remain_ff - 1'b1;
                  maj_in    = major_neg_ff ? (maj_ff - 1'b1) : (maj_ff + 1'b1);
                  acc_in    = acc_next[C-1:0];
                  if (carry) begin
                     min_in = minor_neg_ff ? (min_ff - 1'b1) : (min_ff + 1'b1);
                  end
               end
            end
         end
         ST_FLUSH: begin
            // The point still held back is the last of the segment.
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (!out_full) begin
               out_push      = 1'b1;
               out_data      = {pend_x_ff, pend_y_ff, 1'b1};
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered values; only the control state is reset.
   always_ff @(posedge clock) begin
      maj_ff       <= maj_in;
      min_ff       <= min_in;
      remain_ff    <= remain_in;
      steps_ff     <= steps_in;
      dm_ff        <= dm_in;
      acc_ff       <= acc_in;
      x_major_ff   <= x_major_in;
      major_neg_ff <= major_neg_in;
      minor_neg_ff <= minor_neg_in;
      pend_x_ff    <= pend_x_in;
      pend_y_ff    <= pend_y_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> design/clipped_line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// Clipped line rasteriser core
// Draws one line segment per input transaction with a DDA rule and returns
// the canvas pixels it covers, clipped to the configured canvas.
// ----------------------------------------------------------------------------
// Usage:
//   Push a segment (start and end, signed, may be off canvas) while full is
//   low. Each on-canvas point comes back as one result transaction, in step
//   order, carrying the pen value; the final point of a segment has
//   last_pixel set. A segment wholly off the canvas returns nothing.
//   Timing: the stepper visits one point per cycle along the major axis
//   while the output queue has room. A segment is loaded first, then
//   stepped from the start point until the last step or until the major
//   axis leaves the canvas, and then the held-back last point is released.
//   Two segments can wait in the queue between the front end and the
//   stepper, and two results in the output queue. When the receiver
//   stalls, the output queue fills and the stepper halts on the current
//   point; nothing is lost. Reset empties both queues, idles the stepper
//   and loads the register reset values (canvas 64 by 64, pen value 42).
//   Registers are to be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_line_rasterizer_core
   import clr_pkg::*;
#(
   parameter int MAX_CANVAS = 64,
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   // Segment channel
   input  logic                          push,
   output logic                          full,
   input  logic [COORD_BITS-1:0]         req_x_start,
   input  logic [COORD_BITS-1:0]         req_y_start,
   input  logic [COORD_BITS-1:0]         req_x_end,
   input  logic [COORD_BITS-1:0]         req_y_end,
   // Pixel channel
   output logic                          empty,
   input  logic                          pop,
   output logic [$clog2(MAX_CANVAS)-1:0] rsp_pixel_x,
   output logic [$clog2(MAX_CANVAS)-1:0] rsp_pixel_y,
   output logic [PEN_BITS-1:0]           rsp_pixel_value,
   output logic                          rsp_last_pixel,
   // Configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      paddr,
   input  logic [CSR_DATA_BITS-1:0]      pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready
);

   localparam int PIX       = $clog2(MAX_CANVAS);
   localparam int DESC_BITS = 4 * COORD_BITS + 3;
   localparam int OUT_BITS  = 2 * PIX + 1;
   localparam logic [CFG_BITS-1:0] SIDE_LIMIT = CFG_BITS'(MAX_CANVAS);

   logic [CFG_BITS-1:0] width_ff;
   logic [CFG_BITS-1:0] height_ff;
   logic [PEN_BITS-1:0] pen_ff;
   logic [1:0]          reg_index;
   logic                csr_write;
   canvas_type          canvas;

   logic [DESC_BITS-1:0] front_desc;
   logic [DESC_BITS-1:0] queued_desc;
   logic                 desc_empty;
   logic                 desc_pop;
   logic                 out_push;
   logic [OUT_BITS-1:0]  out_data;
   logic                 out_full;
   logic [OUT_BITS-1:0]  head_data;

   // Configuration registers.
   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_CANVAS_SIDE;
         height_ff <= RESET_CANVAS_SIDE;
         pen_ff    <= RESET_PEN_VALUE;
      end else if (csr_write) begin
         case (reg_index)
            REG_CANVAS_WIDTH:  width_ff  <= pwdata[CFG_BITS-1:0];
            REG_CANVAS_HEIGHT: height_ff <= pwdata[CFG_BITS-1:0];
            REG_PEN_VALUE:     pen_ff    <= pwdata[PEN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_CANVAS_WIDTH:  prdata = CSR_DATA_BITS'(width_ff);
         REG_CANVAS_HEIGHT: prdata = CSR_DATA_BITS'(height_ff);
         REG_PEN_VALUE:     prdata = CSR_DATA_BITS'(pen_ff);
         default:           prdata = '0;
      endcase
   end

   // Canvas sides saturate at the largest supported side.
   assign canvas.width  = (width_ff > SIDE_LIMIT) ? SIDE_LIMIT : width_ff;
   assign canvas.height = (height_ff > SIDE_LIMIT) ? SIDE_LIMIT : height_ff;

   // Front end and the segment queue.
   clr_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .x_start (req_x_start),
      .y_start (req_y_start),
      .x_end   (req_x_end),
      .y_end   (req_y_end),
      .desc    (front_desc)
   );

   clr_fifo #(
      .WIDTH (DESC_BITS),
      .DEPTH (2)
   ) u_desc_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_desc),
      .full      (full),
      .pop       (desc_pop),
      .pop_data  (queued_desc),
      .empty     (desc_empty)
   );

   // Stepper.
   clr_stepper #(
      .MAX_CANVAS (MAX_CANVAS),
      .COORD_BITS (COORD_BITS)
   ) u_stepper (
      .clock      (clock),
      .reset      (reset),
      .desc       (queued_desc),
      .desc_valid (!desc_empty),
      .desc_pop   (desc_pop),
      .canvas     (canvas),
      .out_push   (out_push),
      .out_data   (out_data),
      .out_full   (out_full)
   );

   // Result queue in front of the pixel channel.
   clr_fifo #(
      .WIDTH (OUT_BITS),
      .DEPTH (2)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (head_data),
      .empty     (empty)
   );

   assign {rsp_pixel_x, rsp_pixel_y, rsp_last_pixel} = head_data;
   assign rsp_pixel_value = pen_ff;

endmodule

`default_nettype wire

>>> design/clr_checker.sv
// ----------------------------------------------------------------------------
// Clipped line rasteriser checker
// Watches the ports of the core over time and flags behaviour that the
// channels and the register file must never show.
// ----------------------------------------------------------------------------
`default_nettype none

module clr_checker
   import clr_pkg::*;
#(
   parameter int MAX_CANVAS = 64
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          push,
   input logic                          full,
   input logic                          empty,
   input logic                          pop,
   input logic [$clog2(MAX_CANVAS)-1:0] rsp_pixel_x,
   input logic [$clog2(MAX_CANVAS)-1:0] rsp_pixel_y,
   input logic [PEN_BITS-1:0]           rsp_pixel_value,
   input logic                          rsp_last_pixel,
   input logic                          psel,
   input logic                          penable,
   input logic                          pwrite,
   input logic [CSR_ADDR_BITS-1:0]      paddr,
   input logic [CSR_DATA_BITS-1:0]      pwdata,
   input logic                          pready
);

   logic [PEN_BITS-1:0] pen_ff;
   logic [PEN_BITS-1:0] pen_in;
   logic                pen_write;

   // Shadow copy of the pen register, kept from the write transactions.
   assign pen_write = psel && penable && pwrite && pready && (paddr[3:2] == REG_PEN_VALUE);
   assign pen_in    = pen_write ? pwdata[PEN_BITS-1:0] : pen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff <= RESET_PEN_VALUE;
      end else begin
         pen_ff <= pen_in;
      end
   end

   // Reset leaves the result queue empty and the segment queue not full.
   a_reset_clears : assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("queues not empty after reset");

   // Every pixel carries the pen value last written.
   a_pen_value : assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_pixel_value == pen_ff))
      else $error("pixel value differs from the pen register");

   // The segment queue only fills on an incoming transaction.
   a_full_on_push : assert property (@(posedge clock) disable iff (reset)
      $rose(full) |-> $past(push))
      else $error("full rose without a push");

   // A waiting pixel holds until it is taken.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_pixel_x) && $stable(rsp_pixel_y)
                            && $stable(rsp_last_pixel)))
      else $error("waiting pixel changed before it was taken");

endmodule

bind clipped_line_rasterizer_core clr_checker #(
   .MAX_CANVAS (MAX_CANVAS)
) u_clr_checker (.*);

`default_nettype wire

>>> verif/tb_clipped_line_rasterizer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clipped line rasteriser core testbench
// Pushes line segments through the core and checks every returned pixel
// against a behavioural DDA predictor that clips to the canvas held in the
// testbench's own copy of the registers. Directed segments, register
// settings, a long receiver hold-off and random segments run in turn, with
// random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_clipped_line_rasterizer_core;
   import clr_pkg::*;

   localparam int COORD_BITS      = 12;
   localparam int MAX_CANVAS      = 64;
   localparam int PIX_BITS        = $clog2(MAX_CANVAS);
   localparam logic [1:0] REG_UNUSED = 2'd3;
   // A segment may walk the whole coordinate range before it is retired.
   localparam int SEGMENT_CYCLES  = (1 << COORD_BITS) + 8;
   // Up to three segments can be in flight behind the last pixel.
   localparam int SETTLE_CYCLES   = 3 * SEGMENT_CYCLES;
   localparam int QUIET_LIMIT     = 20 * SEGMENT_CYCLES;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_SEGMENTS = 480;
   localparam int RANDOM_PHASES   = 6;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] x;
      logic [PIX_BITS-1:0] y;
      logic [PEN_BITS-1:0] value;
      logic                last;
   } pixel_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     push;
   logic                     full;
   logic [COORD_BITS-1:0]    req_x_start;
   logic [COORD_BITS-1:0]    req_y_start;
   logic [COORD_BITS-1:0]    req_x_end;
   logic [COORD_BITS-1:0]    req_y_end;
   logic                     empty;
   logic                     pop;
   logic [PIX_BITS-1:0]      rsp_pixel_x;
   logic [PIX_BITS-1:0]      rsp_pixel_y;
   logic [PEN_BITS-1:0]      rsp_pixel_value;
   logic                     rsp_last_pixel;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // Testbench copy of the configuration registers.
   logic [CFG_BITS-1:0]      canvas_width_copy;
   logic [CFG_BITS-1:0]      canvas_height_copy;
   logic [PEN_BITS-1:0]      pen_value_copy;

   pixel_type                expected_pixels[$];
   int                       error_count = 0;
   bit                       idling_on;
   bit                       hold_off_request;

   clipped_line_rasterizer_core #(
      .MAX_CANVAS(MAX_CANVAS),
      .COORD_BITS(COORD_BITS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .empty          (empty),
      .pop            (pop),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_value(rsp_pixel_value),
      .rsp_last_pixel (rsp_last_pixel),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // Clock generation.
   always #1 clock = ~clock;

   // Gap length for either channel: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      if (!idling_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 16);
      return $urandom_range(40, 150);
   endfunction

   // Canvas side as used by the drawing: saturated to the largest side.
   function automatic int usable_side(logic [CFG_BITS-1:0] side);
      return (side > MAX_CANVAS) ? MAX_CANVAS : int'(side);
   endfunction

   // Offset of step i along an axis with difference d, truncated toward zero.
   function automatic int step_offset(int i, int d, int n);
      int q;
      q = (i * ((d < 0) ? -d : d)) / n;
      return (d < 0) ? -q : q;
   endfunction

   // Walk the segment step by step and queue the pixels that land on canvas.
   function automatic void draw_segment(coord_type xs, coord_type ys,
                                        coord_type xe, coord_type ye);
      int        x0, y0, dx, dy, n, w, h, x, y, first, final_index;
      pixel_type p;
      x0 = xs;
      y0 = ys;
      dx = int'(xe) - x0;
      dy = int'(ye) - y0;
      n = ((dx < 0) ? -dx : dx);
      if (((dy < 0) ? -dy : dy) > n) n = (dy < 0) ? -dy : dy;
      w = usable_side(canvas_width_copy);
      h = usable_side(canvas_height_copy);
      first = expected_pixels.size();
      for (int i = 0; i <= n; i++) begin
         x = x0 + ((i == 0) ? 0 : step_offset(i, dx, n));
         y = y0 + ((i == 0) ? 0 : step_offset(i, dy, n));
         if (x >= 0 && x < w && y >= 0 && y < h) begin
            p.x     = x[PIX_BITS-1:0];
            p.y     = y[PIX_BITS-1:0];
            p.value = pen_value_copy;
            p.last  = 1'b0;
            expected_pixels.push_back(p);
         end
      end
      // Mark the final pixel of this segment.
      if (expected_pixels.size() > first) begin
         final_index = expected_pixels.size() - 1;
         p = expected_pixels[final_index];
         p.last = 1'b1;
         expected_pixels[final_index] = p;
      end
   endfunction

   // Offer one segment, wait for the transaction, then idle for a while.
   // Called at a falling edge; returns at a falling edge with push left high
   // when no gap follows.
   task automatic send_segment(input int xs, input int ys, input int xe, input int ye);
      int gap;
      req_x_start <= xs[COORD_BITS-1:0];
      req_y_start <= ys[COORD_BITS-1:0];
      req_x_end   <= xe[COORD_BITS-1:0];
      req_y_end   <= ye[COORD_BITS-1:0];
      push        <= 1'b1;
      do @(posedge clock); while (full);
      draw_segment(coord_type'(xs), coord_type'(ys), coord_type'(xe), coord_type'(ye));
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Let every expected pixel arrive, then give the core time to retire
   // segments that draw nothing.
   task automatic drain_and_settle();
      push <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write: a setup phase, then an access phase until pready, then
   // an idle phase on the port.
   task automatic csr_write(input logic [1:0] index, input logic [CSR_DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_BITS'(index) << 2;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (index)
         REG_CANVAS_WIDTH:  canvas_width_copy  = data[CFG_BITS-1:0];
         REG_CANVAS_HEIGHT: canvas_height_copy = data[CFG_BITS-1:0];
         REG_PEN_VALUE:     pen_value_copy     = data[PEN_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_canvas(input int width, input int height, input int pen);
      drain_and_settle();
      csr_write(REG_CANVAS_WIDTH, width);
      csr_write(REG_CANVAS_HEIGHT, height);
      csr_write(REG_PEN_VALUE, pen);
   endtask

   function automatic int near_coord();
      return int'($urandom_range(0, 159)) - 48;
   endfunction

   function automatic int far_coord();
      return int'($urandom_range(0, (1 << COORD_BITS) - 1)) - (1 << (COORD_BITS - 1));
   endfunction

   // Random segment: mostly around the canvas, some reaching far off it.
   task automatic send_random_segment();
      int roll, xs, ys, xe, ye;
      roll = $urandom_range(0, 99);
      xs = near_coord();
      ys = near_coord();
      xe = near_coord();
      ye = near_coord();
      if (roll < 15) begin
         // Very short segments, single points among them.
         xe = xs + int'($urandom_range(0, 6)) - 3;
         ye = ys + int'($urandom_range(0, 6)) - 3;
      end else if (roll < 80) begin
      end else if (roll < 90) begin
         xe = far_coord();
         ye = far_coord();
         if ($urandom_range(0, 1)) begin
            {xs, xe} = {xe, xs};
            {ys, ye} = {ye, ys};
         end
      end else begin
         xs = far_coord();
         ys = far_coord();
         xe = far_coord();
         ye = far_coord();
      end
      send_segment(xs, ys, xe, ye);
   endtask

   // Reset values, every direction, single points and the coordinate extremes.
   task automatic test_directed_segments();
      send_segment(5, 7, 5, 7);
      send_segment(-1, 0, -1, 0);
      send_segment(2047, 2047, 2047, 2047);
      send_segment(0, 0, 63, 63);
      send_segment(63, 0, 0, 63);
      send_segment(0, 63, 63, 63);
      send_segment(63, 63, 63, 0);
      send_segment(-2048, -2048, 2047, 2047);
      send_segment(2047, -2048, -2048, 2047);
      send_segment(-2048, 5, 2047, 5);
      send_segment(0, -2048, 0, 2047);
      send_segment(100, 100, 200, 300);
      send_segment(10, -5, 3, 60);
      send_segment(-20, 30, 90, 10);
      send_segment(64, 0, 64, 63);
      send_segment(40, 70, -10, -9);
   endtask

   // Canvas extremes, a zero side, saturation, ignored data bits and the
   // address beyond the register list.
   task automatic test_canvas_registers();
      set_canvas(1, 1, 255);
      send_segment(0, 0, 0, 0);
      send_segment(-3, -3, 3, 3);
      send_segment(1, 0, 1, 0);
      set_canvas(0, 64, 0);
      send_segment(0, 0, 63, 63);
      send_segment(10, 5, 10, 5);
      set_canvas(64, 0, 7);
      send_segment(0, 0, 63, 63);
      set_canvas(127, 100, 128);
      send_segment(0, 0, 126, 99);
      send_segment(-5, 70, 90, -20);
      set_canvas(32'hFFFF_FF85, 32'hFFFF_FF03, 32'h1234_5601);
      send_segment(0, 0, 10, 4);
      drain_and_settle();
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      send_segment(0, 0, 10, 4);
      send_segment(4, 2, -4, 2);
   endtask

   // Hold the receiver off while full-length segments keep coming.
   task automatic test_output_backpressure();
      set_canvas(64, 64, 85);
      idling_on = 1'b0;
      hold_off_request = 1'b1;
      for (int k = 0; k < 8; k++) send_segment(k, 0, 63, 63 - k);
      drain_and_settle();
      idling_on = 1'b1;
   endtask

   // Random segments over several canvas settings, one phase without gaps.
   task automatic test_random_segments();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: set_canvas(64, 64, $urandom_range(0, 255));
            1: set_canvas($urandom_range(1, 63), $urandom_range(1, 63), $urandom_range(0, 255));
            2: set_canvas(64, 1, 0);
            3: set_canvas(1, 64, 255);
            4: set_canvas($urandom_range(65, 127), $urandom_range(1, 127), $urandom_range(0, 255));
            default: set_canvas($urandom_range(0, 127), $urandom_range(1, 127),
                                $urandom_range(0, 255));
         endcase
         idling_on = (phase != 2);
         for (int k = 0; k < RANDOM_SEGMENTS / RANDOM_PHASES; k++) send_random_segment();
      end
      idling_on = 1'b1;
   endtask

   // Pixel receiver: random pop gaps, plus one long hold-off on request.
   initial begin : pixel_receiver
      int stall;
      stall = 0;
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            pop <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else if (stall > 0) begin
            pop <= 1'b0;
            stall--;
         end else begin
            pop <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   function automatic void check_field(string field_name, int want, int got);
      if (want != got) begin
         $display("%0t ns: pixel %s mismatch, expected %0d, actual %0d",
                  $time, field_name, want, got);
         error_count++;
      end
   endfunction

   // Compare each accepted pixel transaction with the oldest expectation.
   always @(posedge clock) begin : pixel_checker
      pixel_type want;
      if (!reset && pop && !empty) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t ns: unexpected pixel, expected none, actual x=%0d y=%0d value=%0d last=%0b",
                     $time, rsp_pixel_x, rsp_pixel_y, rsp_pixel_value, rsp_last_pixel);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("x", want.x, rsp_pixel_x);
            check_field("y", want.y, rsp_pixel_y);
            check_field("value", want.value, rsp_pixel_value);
            check_field("last", want.last, rsp_last_pixel);
         end
      end
   end

   // Watchdog: ends the run after too long without any transaction.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (push && !full) || (pop && !empty)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("clipped_line_rasterizer_core test failed");
      $finish;
   end

   // Main sequence.
   initial begin
      reset            = 1'b1;
      push             = 1'b0;
      req_x_start      = '0;
      req_y_start      = '0;
      req_x_end        = '0;
      req_y_end        = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      idling_on        = 1'b1;
      hold_off_request = 1'b0;
      canvas_width_copy  = RESET_CANVAS_SIDE;
      canvas_height_copy = RESET_CANVAS_SIDE;
      pen_value_copy     = RESET_PEN_VALUE;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_segments();
      test_canvas_registers();
      test_output_backpressure();
      test_random_segments();

      drain_and_settle();
      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("clipped_line_rasterizer_core test passed");
      end else begin
         $display("clipped_line_rasterizer_core test failed");
      end
      $finish;
   end

endmodule

>>> files.f
design/clr_pkg.sv
design/clr_fifo.sv
design/clr_front.sv
design/clr_stepper.sv
design/clipped_line_rasterizer_core.sv
design/clr_checker.sv
verif/tb_clipped_line_rasterizer_core.sv
